// ----- sv/eapf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eapf_pkg
// Shared types and constants for the egress packet allowlist filter.
// ----------------------------------------------------------------------------
package eapf_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_ADD   = 2'd1,
    OP_REM   = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    R_ARP        = 4'd0,
    R_DNS        = 4'd1,
    R_TCP_OK     = 4'd2,
    R_SHORT      = 4'd3,
    R_ETHERTYPE  = 4'd4,
    R_VERSION    = 4'd5,
    R_OPTIONS    = 4'd6,
    R_FRAGMENT   = 4'd7,
    R_ICMP       = 4'd8,
    R_UDP_PORT   = 4'd9,
    R_TCP_DENIED = 4'd10,
    R_OTHER      = 4'd11
  } reason_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  localparam logic [15:0] DNS_PORT_RST = 16'd53;
  localparam logic [15:0] ETH_ARP      = 16'h0806;
  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [15:0] FRAG_MASK    = 16'h3fff;
  localparam logic [3:0]  IP_VERSION   = 4'd4;
  localparam logic [3:0]  IP_IHL       = 4'd5;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;

  // byte positions and minimum lengths
  localparam logic [5:0] BYTE_MAX      = 6'd63;
  localparam logic [5:0] POS_ETYPE_HI  = 6'd12;
  localparam logic [5:0] POS_ETYPE_LO  = 6'd13;
  localparam logic [5:0] POS_VER_IHL   = 6'd14;
  localparam logic [5:0] POS_FRAG_HI   = 6'd20;
  localparam logic [5:0] POS_FRAG_LO   = 6'd21;
  localparam logic [5:0] POS_PROTO     = 6'd23;
  localparam logic [5:0] POS_DADDR_LO  = 6'd30;
  localparam logic [5:0] POS_DADDR_HI  = 6'd33;
  localparam logic [5:0] POS_DPORT_HI  = 6'd36;
  localparam logic [5:0] POS_DPORT_LO  = 6'd37;
  localparam logic [5:0] LEN_ETH       = 6'd14;
  localparam logic [5:0] LEN_IP        = 6'd34;
  localparam logic [5:0] LEN_UDP       = 6'd42;
  localparam logic [5:0] LEN_TCP       = 6'd54;

  // request handed from the parser to the table stage
  typedef struct packed {
    logic        valid;
    logic        is_table;
    logic        is_rem;
    logic        lookup;
    reason_e     reason;
    logic [31:0] key;
  } req_t;

  // command broadcast along the cell row
  typedef struct packed {
    logic        add_en;
    logic        rem_en;
    logic [31:0] key;
  } cell_cmd_t;

endpackage : eapf_pkg
`default_nettype wire

// ----- sv/eapf_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eapf_if
// Valid/ready channels of the filter: input beats, results, configuration.
// ----------------------------------------------------------------------------
interface eapf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  data_byte;
  logic        last;
  logic [31:0] ip_addr;

  modport source (output valid, output op, output data_byte, output last,
                  output ip_addr, input ready);
  modport sink   (input valid, input op, input data_byte, input last,
                  input ip_addr, output ready);
endinterface : eapf_in_if

interface eapf_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       drop;
  logic [3:0] verdict_reason;
  logic [1:0] table_status;

  modport source (output valid, output kind, output drop, output verdict_reason,
                  output table_status, input ready);
  modport sink   (input valid, input kind, input drop, input verdict_reason,
                  input table_status, output ready);
endinterface : eapf_out_if

interface eapf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : eapf_cfg_if
`default_nettype wire

// ----- sv/eapf_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eapf_cell
// One allowlist entry: compares the broadcast key and passes the "free slot
// seen" flag on to the next cell so that an add lands in the first free one.
// ----------------------------------------------------------------------------
module eapf_cell import eapf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_cmd_t cmd_i,
  input  wire logic      free_i,
  output      logic      free_o,
  output      logic      match_o
);

  logic        valid_q;
  logic [31:0] addr_q;
  logic        wr;

  assign match_o = valid_q && (addr_q == cmd_i.key);
  assign free_o  = free_i | ~valid_q;
  assign wr      = cmd_i.add_en & ~free_i & ~valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr) begin
      valid_q <= 1'b1;
    end else if (cmd_i.rem_en && match_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      addr_q <= cmd_i.key;
    end
  end

endmodule : eapf_cell
`default_nettype wire

// ----- sv/eapf_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eapf_parser
// Header field capture per frame beat and verdict precompute on the last beat.
// ----------------------------------------------------------------------------
module eapf_parser import eapf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  input  wire logic [31:0] ip_addr_i,
  input  wire logic [15:0] dns_port_i,
  output      req_t        req_o
);

  logic [5:0]  cnt_q,   cnt_d;
  logic [15:0] etype_q, etype_d;
  logic [7:0]  verihl_q, verihl_d;
  logic [15:0] frag_q,  frag_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] daddr_q, daddr_d;
  logic [15:0] dport_q, dport_d;
  logic        is_frame;
  logic        is_table;
  reason_e     reason;
  logic        lookup;

  assign is_frame = (op_i == OP_FRAME);
  assign is_table = (op_i == OP_ADD) || (op_i == OP_REM);

  // fields with the current byte folded in
  always_comb begin
    etype_d  = etype_q;
    verihl_d = verihl_q;
    frag_d   = frag_q;
    proto_d  = proto_q;
    daddr_d  = daddr_q;
    dport_d  = dport_q;
    cnt_d    = (cnt_q == BYTE_MAX) ? cnt_q : cnt_q + 6'd1;
    if (cnt_q == POS_ETYPE_HI || cnt_q == POS_ETYPE_LO) begin
      etype_d = {etype_q[7:0], data_byte_i};
    end else if (cnt_q == POS_VER_IHL) begin
      verihl_d = data_byte_i;
    end else if (cnt_q == POS_FRAG_HI || cnt_q == POS_FRAG_LO) begin
      frag_d = {frag_q[7:0], data_byte_i};
    end else if (cnt_q == POS_PROTO) begin
      proto_d = data_byte_i;
    end else if (cnt_q >= POS_DADDR_LO && cnt_q <= POS_DADDR_HI) begin
      daddr_d = {daddr_q[23:0], data_byte_i};
    end else if (cnt_q == POS_DPORT_HI || cnt_q == POS_DPORT_LO) begin
      dport_d = {dport_q[7:0], data_byte_i};
    end
  end

  // verdict; a TCP frame long enough is settled later by the table lookup
  always_comb begin
    lookup = 1'b0;
    if (cnt_d < LEN_ETH) begin
      reason = R_SHORT;
    end else if (etype_d == ETH_ARP) begin
      reason = R_ARP;
    end else if (etype_d != ETH_IPV4) begin
      reason = R_ETHERTYPE;
    end else if (cnt_d < LEN_IP) begin
      reason = R_SHORT;
    end else if (verihl_d[7:4] != IP_VERSION) begin
      reason = R_VERSION;
    end else if (verihl_d[3:0] != IP_IHL) begin
      reason = R_OPTIONS;
    end else if ((frag_d & FRAG_MASK) != 16'd0) begin
      reason = R_FRAGMENT;
    end else if (proto_d == PROTO_ICMP) begin
      reason = R_ICMP;
    end else if (proto_d == PROTO_UDP) begin
      if (cnt_d < LEN_UDP) begin
        reason = R_SHORT;
      end else if (dport_d == dns_port_i) begin
        reason = R_DNS;
      end else begin
        reason = R_UDP_PORT;
      end
    end else if (proto_d == PROTO_TCP) begin
      if (cnt_d < LEN_TCP) begin
        reason = R_SHORT;
      end else begin
        reason = R_TCP_DENIED;
        lookup = 1'b1;
      end
    end else begin
      reason = R_OTHER;
    end
  end

  always_comb begin
    req_o.valid    = accept_i && ((is_frame && last_i) || is_table);
    req_o.is_table = is_table;
    req_o.is_rem   = (op_i == OP_REM);
    req_o.lookup   = is_frame && lookup;
    req_o.reason   = reason;
    req_o.key      = is_table ? ip_addr_i : daddr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      etype_q  <= '0;
      verihl_q <= '0;
      frag_q   <= '0;
      proto_q  <= '0;
      daddr_q  <= '0;
      dport_q  <= '0;
    end else if (accept_i && is_frame) begin
      if (last_i) begin
        cnt_q    <= '0;
        etype_q  <= '0;
        verihl_q <= '0;
        frag_q   <= '0;
        proto_q  <= '0;
        daddr_q  <= '0;
        dport_q  <= '0;
      end else begin
        cnt_q    <= cnt_d;
        etype_q  <= etype_d;
        verihl_q <= verihl_d;
        frag_q   <= frag_d;
        proto_q  <= proto_d;
        daddr_q  <= daddr_d;
        dport_q  <= dport_d;
      end
    end
  end

endmodule : eapf_parser
`default_nettype wire

// ----- sv/egress_packet_allowlist_filter_top.sv -----
`default_nettype none
// Path of a result: parse stage, table stage, output register.
// Throughput: one beat per cycle unless out_o.ready stalls the output;
// the table stage compares all entries at once and writes in the same cycle,
// so back-to-back table ops see each other.
// Reset: allowlist empty, capture state cleared, dns_port 53; no clearing pass.
// ----------------------------------------------------------------------------
// egress_packet_allowlist_filter_top
// IPv4 egress filter with a destination-address allowlist in a row of cells.
// ----------------------------------------------------------------------------
module egress_packet_allowlist_filter_top import eapf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  eapf_cfg_if.sink  cfg_i,
  eapf_in_if.sink   in_i,
  eapf_out_if.source out_o
);

  logic [15:0]              dns_port_q;
  logic                     accept;
  logic                     adv;
  req_t                     req;
  logic                     s1_valid_q;
  req_t                     s1_q;
  logic                     out_valid_q;
  logic                     out_kind_q;
  logic                     out_drop_q;
  reason_e                  out_reason_q;
  status_e                  out_status_q;
  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES:0]   free_c;
  logic                     found;
  logic                     commit;
  cell_cmd_t                cmd;
  reason_e                  reason_fin;
  status_e                  status_fin;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dns_port_q <= DNS_PORT_RST;
    end else if (cfg_i.valid) begin
      dns_port_q <= cfg_i.data;
    end
  end

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || adv;
  assign accept     = in_i.valid && in_i.ready;

  eapf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (in_i.op),
    .data_byte_i (in_i.data_byte),
    .last_i      (in_i.last),
    .ip_addr_i   (in_i.ip_addr),
    .dns_port_i  (dns_port_q),
    .req_o       (req)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && req.valid) begin
      s1_q <= req;
    end
  end

  // table stage: the command only takes effect when the stage moves on
  assign commit     = s1_valid_q && adv;
  assign found      = |match;
  assign cmd.key    = s1_q.key;
  assign cmd.add_en = commit && s1_q.is_table && !s1_q.is_rem && !found;
  assign cmd.rem_en = commit && s1_q.is_table && s1_q.is_rem;
  assign free_c[0]  = 1'b0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    eapf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .free_i  (free_c[g]),
      .free_o  (free_c[g+1]),
      .match_o (match[g])
    );
  end

  always_comb begin
    reason_fin = s1_q.reason;
    if (s1_q.lookup) begin
      reason_fin = found ? R_TCP_OK : R_TCP_DENIED;
    end
    if (s1_q.is_rem) begin
      status_fin = found ? ST_OK : ST_NOT_FOUND;
    end else begin
      status_fin = (found || free_c[TABLE_ENTRIES]) ? ST_OK : ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_kind_q <= s1_q.is_table;
      if (s1_q.is_table) begin
        out_drop_q   <= 1'b0;
        out_reason_q <= R_ARP;
        out_status_q <= status_fin;
      end else begin
        out_drop_q   <= (reason_fin > R_TCP_OK);
        out_reason_q <= reason_fin;
        out_status_q <= ST_OK;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_kind_q;
  assign out_o.drop           = out_drop_q;
  assign out_o.verdict_reason = out_reason_q;
  assign out_o.table_status   = out_status_q;

`ifndef SYNTH
  // an address is never held twice
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(match))
    else $error("allowlist holds a duplicate address");

  a_lookup_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.lookup) |-> !s1_q.is_table)
    else $error("table op marked for a frame lookup");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_add_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.add_en && free_c[TABLE_ENTRIES] |=> !free_c[TABLE_ENTRIES] || $past(free_c[TABLE_ENTRIES]))
    else $error("add with a free entry did not land");
`endif

endmodule : egress_packet_allowlist_filter_top
`default_nettype wire

// ----- tb/tb_egress_packet_allowlist_filter_top.sv -----
// ----------------------------------------------------------------------------
// tb_egress_packet_allowlist_filter_top
// Self-checking bench for the egress allowlist filter. Frame bytes and table
// ops are driven through the input channel with random gaps. A local model of
// the capture registers, the allowlist and dns_port predicts each verdict and
// table status. The receiver compares every result beat in order. A directed
// table covers the verdict order and table corner cases. Random phases follow,
// one per dns_port setting.
// ----------------------------------------------------------------------------
module tb_egress_packet_allowlist_filter_top;
  import eapf_pkg::*;

  localparam logic [1:0] OP_NOP       = 2'd3;
  localparam logic       KIND_VERDICT = 1'b0;
  localparam logic       KIND_TABLE   = 1'b1;
  localparam int         HDR_BYTES    = POS_DPORT_LO + 1;
  localparam int         POOL_SIZE    = 96;
  localparam int         PHASE_BEATS  = 130;
  localparam int         PHASE_MIN_RESULTS = 4;
  localparam int         HOLD_AT      = 60;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         QUIET_LIMIT  = 3000;
  localparam int         N_PROBES     = 29;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] ip_addr;
  } beat_t;

  typedef struct packed {
    logic    kind;
    logic    drop;
    reason_e reason;
    status_e status;
  } outcome_t;

  typedef logic [7:0] frame_q_t [$];

  // frame rows: len is the frame length; table rows: len is the op count
  typedef struct {
    logic [1:0]  op;
    int          len;
    logic [15:0] etype;
    logic [7:0]  vihl;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] addr;
    logic [15:0] dport;
    int          mid_at;
    logic        fixed;
    reason_e     why;
    status_e     stat;
  } probe_t;

  logic clk_i;
  logic rst_ni;

  eapf_cfg_if cfg_ch ();
  eapf_in_if  in_ch ();
  eapf_out_if out_ch ();

  egress_packet_allowlist_filter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // model state
  logic [5:0]  cap_count;
  logic [15:0] cap_etype;
  logic [7:0]  cap_ver_ihl;
  logic [15:0] cap_frag;
  logic [7:0]  cap_proto;
  logic [31:0] cap_daddr;
  logic [15:0] cap_dport;
  logic [31:0] list_addr [TABLE_ENTRIES];
  logic        list_used [TABLE_ENTRIES];
  logic [15:0] allowed_dns_port;

  outcome_t pending_outcomes [$];
  int       fails;
  int       beats_sent;
  int       outcomes_made;
  bit       sender_dense;
  int       quiet_cycles;
  logic [31:0] addr_pool [POOL_SIZE];

  probe_t probes [N_PROBES] = '{
    '{OP_FRAME, 1,  ETH_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'h0, 16'd0, -1, 1'b1,
      R_SHORT, ST_OK},
    '{OP_FRAME, 13, ETH_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'h0, 16'd0, -1, 1'b1,
      R_SHORT, ST_OK},
    '{OP_FRAME, 14, ETH_ARP, 8'h45, 16'h0000, PROTO_TCP, 32'h0, 16'd0, -1, 1'b1,
      R_ARP, ST_OK},
    '{OP_FRAME, 60, 16'hffff, 8'h45, 16'h0000, PROTO_UDP, 32'h0, 16'd53, -1, 1'b1,
      R_ETHERTYPE, ST_OK},
    '{OP_FRAME, 33, ETH_IPV4, 8'h45, 16'h0000, PROTO_UDP, 32'h0, 16'd53, -1, 1'b1,
      R_SHORT, ST_OK},
    '{OP_FRAME, 60, ETH_IPV4, 8'hf5, 16'h0000, PROTO_UDP, 32'h0, 16'd53, -1, 1'b1,
      R_VERSION, ST_OK},
    '{OP_FRAME, 60, ETH_IPV4, 8'h4f, 16'h0000, PROTO_UDP, 32'h0, 16'd53, -1, 1'b1,
      R_OPTIONS, ST_OK},
    '{OP_FRAME, 60, ETH_IPV4, 8'h45, 16'h2000, PROTO_UDP, 32'h0, 16'd53, -1, 1'b1,
      R_FRAGMENT, ST_OK},
    '{OP_FRAME, 60, ETH_IPV4, 8'h45, 16'h0001, PROTO_UDP, 32'h0, 16'd53, -1, 1'b1,
      R_FRAGMENT, ST_OK},
    // DF and the reserved bit are outside the fragment mask
    '{OP_FRAME, 42, ETH_IPV4, 8'h45, 16'hc000, PROTO_UDP, 32'h0, 16'd53, -1, 1'b0,
      R_ARP, ST_OK},
    '{OP_FRAME, 60, ETH_IPV4, 8'h45, 16'h4000, PROTO_ICMP, 32'h0, 16'd53, -1, 1'b1,
      R_ICMP, ST_OK},
    '{OP_FRAME, 42, ETH_IPV4, 8'h45, 16'h0000, PROTO_UDP, 32'h0, 16'd53, -1, 1'b1,
      R_DNS, ST_OK},
    '{OP_FRAME, 41, ETH_IPV4, 8'h45, 16'h0000, PROTO_UDP, 32'h0, 16'd53, -1, 1'b1,
      R_SHORT, ST_OK},
    '{OP_FRAME, 42, ETH_IPV4, 8'h45, 16'h0000, PROTO_UDP, 32'h0, 16'hffff, -1, 1'b1,
      R_UDP_PORT, ST_OK},
    '{OP_FRAME, 34, ETH_IPV4, 8'h45, 16'h0000, 8'hff, 32'h0, 16'd53, -1, 1'b1,
      R_OTHER, ST_OK},
    '{OP_FRAME, 53, ETH_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hc0a8_0001, 16'd0, -1, 1'b1,
      R_SHORT, ST_OK},
    '{OP_FRAME, 54, ETH_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hc0a8_0001, 16'd0, -1, 1'b1,
      R_TCP_DENIED, ST_OK},
    '{OP_ADD, 1, 16'h0, 8'h0, 16'h0, 8'h0, 32'hc0a8_0001, 16'd0, -1, 1'b1, R_ARP, ST_OK},
    '{OP_ADD, 1, 16'h0, 8'h0, 16'h0, 8'h0, 32'hc0a8_0001, 16'd0, -1, 1'b1, R_ARP, ST_OK},
    // long frame, byte count saturates
    '{OP_FRAME, 70, ETH_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hc0a8_0001, 16'd0, -1, 1'b0,
      R_ARP, ST_OK},
    '{OP_REM, 1, 16'h0, 8'h0, 16'h0, 8'h0, 32'h0, 16'd0, -1, 1'b1, R_ARP, ST_NOT_FOUND},
    '{OP_NOP, 1, 16'h0, 8'h0, 16'h0, 8'h0, 32'h0, 16'd0, -1, 1'b0, R_ARP, ST_OK},
    // table op lands in the middle of the destination address
    '{OP_FRAME, 54, ETH_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'h0a00_0001, 16'd0, 31, 1'b0,
      R_ARP, ST_OK},
    '{OP_REM, 1, 16'h0, 8'h0, 16'h0, 8'h0, 32'hc0a8_0001, 16'd0, -1, 1'b1, R_ARP, ST_OK},
    '{OP_ADD, TABLE_ENTRIES, 16'h0, 8'h0, 16'h0, 8'h0, 32'hffff_ffc0, 16'd0, -1, 1'b0,
      R_ARP, ST_OK},
    '{OP_ADD, 1, 16'h0, 8'h0, 16'h0, 8'h0, 32'h0, 16'd0, -1, 1'b1, R_ARP, ST_FULL},
    '{OP_REM, 1, 16'h0, 8'h0, 16'h0, 8'h0, 32'hffff_ffc0, 16'd0, -1, 1'b1, R_ARP, ST_OK},
    '{OP_ADD, 1, 16'h0, 8'h0, 16'h0, 8'h0, 32'h0, 16'd0, -1, 1'b1, R_ARP, ST_OK},
    '{OP_FRAME, 54, ETH_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'h0, 16'd0, -1, 1'b0,
      R_ARP, ST_OK}
  };

  function automatic int list_slot(input logic [31:0] addr);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (list_used[i] && list_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // advances the model by one beat; returns 1 when the beat yields a result
  function automatic bit predict_filter(input beat_t b, output outcome_t res);
    int      slot;
    reason_e why;
    res = '0;
    if (b.op == OP_FRAME) begin
      if (cap_count == POS_ETYPE_HI || cap_count == POS_ETYPE_LO) begin
        cap_etype = {cap_etype[7:0], b.data_byte};
      end else if (cap_count == POS_VER_IHL) begin
        cap_ver_ihl = b.data_byte;
      end else if (cap_count == POS_FRAG_HI || cap_count == POS_FRAG_LO) begin
        cap_frag = {cap_frag[7:0], b.data_byte};
      end else if (cap_count == POS_PROTO) begin
        cap_proto = b.data_byte;
      end else if (cap_count >= POS_DADDR_LO && cap_count <= POS_DADDR_HI) begin
        cap_daddr = {cap_daddr[23:0], b.data_byte};
      end else if (cap_count == POS_DPORT_HI || cap_count == POS_DPORT_LO) begin
        cap_dport = {cap_dport[7:0], b.data_byte};
      end
      if (cap_count != BYTE_MAX) cap_count = cap_count + 6'd1;
      if (!b.last) return 1'b0;

      if (cap_count < LEN_ETH) why = R_SHORT;
      else if (cap_etype == ETH_ARP) why = R_ARP;
      else if (cap_etype != ETH_IPV4) why = R_ETHERTYPE;
      else if (cap_count < LEN_IP) why = R_SHORT;
      else if (cap_ver_ihl[7:4] != IP_VERSION) why = R_VERSION;
      else if (cap_ver_ihl[3:0] != IP_IHL) why = R_OPTIONS;
      else if ((cap_frag & FRAG_MASK) != 16'd0) why = R_FRAGMENT;
      else if (cap_proto == PROTO_ICMP) why = R_ICMP;
      else if (cap_proto == PROTO_UDP) begin
        if (cap_count < LEN_UDP) why = R_SHORT;
        else if (cap_dport == allowed_dns_port) why = R_DNS;
        else why = R_UDP_PORT;
      end else if (cap_proto == PROTO_TCP) begin
        if (cap_count < LEN_TCP) why = R_SHORT;
        else if (list_slot(cap_daddr) >= 0) why = R_TCP_OK;
        else why = R_TCP_DENIED;
      end else why = R_OTHER;

      res.kind   = KIND_VERDICT;
      res.drop   = (why > R_TCP_OK);
      res.reason = why;
      res.status = ST_OK;
      cap_count   = '0;
      cap_etype   = '0;
      cap_ver_ihl = '0;
      cap_frag    = '0;
      cap_proto   = '0;
      cap_daddr   = '0;
      cap_dport   = '0;
      return 1'b1;
    end
    if (b.op == OP_ADD || b.op == OP_REM) begin
      slot = list_slot(b.ip_addr);
      res.kind   = KIND_TABLE;
      res.drop   = 1'b0;
      res.reason = R_ARP;
      res.status = ST_OK;
      if (b.op == OP_ADD) begin
        if (slot < 0) begin
          res.status = ST_FULL;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!list_used[i]) begin
              list_used[i] = 1'b1;
              list_addr[i] = b.ip_addr;
              res.status   = ST_OK;
              break;
            end
          end
        end
      end else if (slot < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        list_used[slot] = 1'b0;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void build_frame(input int len, input logic [15:0] etype,
                                      input logic [7:0] vihl, input logic [15:0] frag,
                                      input logic [7:0] proto, input logic [31:0] daddr,
                                      input logic [15:0] dport, output frame_q_t f);
    logic [7:0] hdr [HDR_BYTES];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[POS_ETYPE_HI] = etype[15:8];
    hdr[POS_ETYPE_LO] = etype[7:0];
    hdr[POS_VER_IHL]  = vihl;
    hdr[POS_FRAG_HI]  = frag[15:8];
    hdr[POS_FRAG_LO]  = frag[7:0];
    hdr[POS_PROTO]    = proto;
    for (int k = 0; k < 4; k++) hdr[POS_DADDR_LO + k] = daddr[31 - 8 * k -: 8];
    hdr[POS_DPORT_HI] = dport[15:8];
    hdr[POS_DPORT_LO] = dport[7:0];
    f = {};
    for (int i = 0; i < len; i++) f.push_back(i < HDR_BYTES ? hdr[i] : 8'($urandom));
  endfunction

  // called at a clock edge; returns at the edge where the beat is accepted
  task automatic push_beat(input beat_t b, input bit fixed, input outcome_t want);
    outcome_t res;
    int       gap;
    gap = sender_dense ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= b.op;
    in_ch.data_byte <= b.data_byte;
    in_ch.last      <= b.last;
    in_ch.ip_addr   <= b.ip_addr;
    do @(posedge clk_i); while (!in_ch.ready);
    if (predict_filter(b, res)) begin
      pending_outcomes.push_back(fixed ? want : res);
      outcomes_made++;
    end
    if (b.op != OP_NOP) beats_sent++;
  endtask

  task automatic send_frame(input frame_q_t bytes, input int mid_at, input beat_t mid,
                            input bit fixed, input reason_e why);
    beat_t    b;
    outcome_t want;
    want = '{KIND_VERDICT, (why > R_TCP_OK), why, ST_OK};
    foreach (bytes[i]) begin
      if (i == mid_at) push_beat(mid, 1'b0, want);
      b.op        = OP_FRAME;
      b.data_byte = bytes[i];
      b.last      = (i == bytes.size() - 1);
      b.ip_addr   = $urandom;
      push_beat(b, fixed && b.last, want);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    // beats with no result may still be in the pipe
    repeat (8) @(posedge clk_i);
  endtask

  // result receiver
  initial begin
    int       stall;
    int       got;
    bit       dense;
    outcome_t want;
    out_ch.ready <= 1'b0;
    got   = 0;
    dense = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (got % 48 == 0) dense = ($urandom_range(0, 2) == 0);
      if (got == HOLD_AT) stall = HOLD_CYCLES;
      else stall = dense ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result beat: kind %0d drop %0d reason %0d status %0d",
               out_ch.kind, out_ch.drop, out_ch.verdict_reason, out_ch.table_status);
        fails++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          fails++;
        end
        if (out_ch.drop !== want.drop) begin
          $error("drop: expected %0d, got %0d", want.drop, out_ch.drop);
          fails++;
        end
        if (out_ch.verdict_reason !== want.reason) begin
          $error("verdict_reason: expected %0d, got %0d", want.reason,
                 out_ch.verdict_reason);
          fails++;
        end
        if (out_ch.table_status !== want.status) begin
          $error("table_status: expected %0d, got %0d", want.status, out_ch.table_status);
          fails++;
        end
      end
      got++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("egress_packet_allowlist_filter_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    probe_t      p;
    beat_t       b;
    beat_t       mid;
    frame_q_t    bytes;
    logic [15:0] etype;
    logic [7:0]  vihl;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] daddr;
    logic [15:0] dport;
    logic [15:0] dns_setting;
    int          len;
    int          need;
    int          mid_at;
    int          add_pct;
    int          pick;
    int          r;

    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_FRAME;
    in_ch.data_byte <= '0;
    in_ch.last      <= 1'b0;
    in_ch.ip_addr   <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    fails         = 0;
    beats_sent    = 0;
    outcomes_made = 0;
    sender_dense  = 1'b0;
    quiet_cycles  = 0;
    cap_count   = '0;
    cap_etype   = '0;
    cap_ver_ihl = '0;
    cap_frag    = '0;
    cap_proto   = '0;
    cap_daddr   = '0;
    cap_dport   = '0;
    foreach (list_used[i]) begin
      list_used[i] = 1'b0;
      list_addr[i] = '0;
    end
    allowed_dns_port = DNS_PORT_RST;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hffff_ffff;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    foreach (probes[n]) begin
      p = probes[n];
      if (p.op == OP_FRAME) begin
        build_frame(p.len, p.etype, p.vihl, p.frag, p.proto, p.addr, p.dport, bytes);
        mid.op        = OP_ADD;
        mid.ip_addr   = p.addr;
        mid.data_byte = 8'($urandom);
        mid.last      = 1'($urandom);
        send_frame(bytes, p.mid_at, mid, p.fixed, p.why);
      end else begin
        for (int k = 0; k < p.len; k++) begin
          b.op        = p.op;
          b.ip_addr   = p.addr + k;
          b.data_byte = 8'($urandom);
          b.last      = 1'($urandom);
          push_beat(b, p.fixed, '{KIND_TABLE, 1'b0, R_ARP, p.stat});
        end
      end
    end

    // random phases, one per dns_port setting
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: dns_setting = 16'h0000;
        1: dns_setting = 16'hffff;
        2: dns_setting = 16'($urandom);
        default: dns_setting = DNS_PORT_RST;
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= dns_setting;
      do @(posedge clk_i); while (!cfg_ch.ready);
      cfg_ch.valid <= 1'b0;
      allowed_dns_port = dns_setting;

      // phase 1 leans on adds so the table fills up
      add_pct = (ph == 1) ? 85 : (ph == 2) ? 25 : 50;
      beats_sent    = 0;
      outcomes_made = 0;
      while (beats_sent < PHASE_BEATS || outcomes_made < PHASE_MIN_RESULTS) begin
        if ($urandom_range(0, 15) == 0) sender_dense = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          b.op        = OP_NOP;
          b.data_byte = 8'($urandom);
          b.last      = 1'($urandom);
          b.ip_addr   = $urandom;
          push_beat(b, 1'b0, '0);
        end else if (pick < 40) begin
          b.op        = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REM;
          b.data_byte = 8'($urandom);
          b.last      = 1'($urandom);
          b.ip_addr   = ($urandom_range(0, 4) != 0) ?
                        addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
          push_beat(b, 1'b0, '0);
        end else begin
          r = $urandom_range(0, 99);
          etype = (r < 80) ? ETH_IPV4 : (r < 88) ? ETH_ARP : 16'($urandom);
          vihl  = ($urandom_range(0, 99) < 85) ? 8'h45 : 8'($urandom);
          r = $urandom_range(0, 99);
          frag  = (r < 45) ? 16'h0000 : (r < 85) ? 16'h4000 : 16'($urandom);
          r = $urandom_range(0, 99);
          proto = (r < 40) ? PROTO_TCP : (r < 75) ? PROTO_UDP :
                  (r < 83) ? PROTO_ICMP : 8'($urandom);
          daddr = ($urandom_range(0, 9) < 7) ?
                  addr_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
          dport = $urandom_range(0, 1) ? allowed_dns_port : 16'($urandom);
          if (etype != ETH_IPV4) need = LEN_ETH;
          else if (proto == PROTO_TCP) need = LEN_TCP;
          else if (proto == PROTO_UDP) need = LEN_UDP;
          else need = LEN_IP;
          r = $urandom_range(0, 99);
          if (r < 8) begin
            len = $urandom_range(1, need - 1);
          end else if (r < 13) begin
            len = $urandom_range(64, 90);
          end else if (r < 18) begin
            // noise: ethertype, version/IHL, fragment and protocol fields fully random
            etype = 16'($urandom);
            vihl  = 8'($urandom);
            frag  = 16'($urandom);
            proto = 8'($urandom);
            len   = $urandom_range(1, 70);
          end else begin
            len = $urandom_range(need, need + 8);
          end
          mid_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
          r = $urandom_range(0, 2);
          mid.op        = (r == 0) ? OP_ADD : (r == 1) ? OP_REM : OP_NOP;
          mid.data_byte = 8'($urandom);
          mid.last      = 1'($urandom);
          mid.ip_addr   = $urandom_range(0, 1) ? daddr : $urandom;
          build_frame(len, etype, vihl, frag, proto, daddr, dport, bytes);
          send_frame(bytes, mid_at, mid, 1'b0, R_ARP);
        end
      end
    end

    drain_results();
    if (fails == 0) begin
      $display("egress_packet_allowlist_filter_top regression: pass");
    end else begin
      $display("egress_packet_allowlist_filter_top regression: fail");
    end
    $finish;
  end

endmodule : tb_egress_packet_allowlist_filter_top

// ----- sim.f -----
sv/eapf_pkg.sv
sv/eapf_if.sv
sv/eapf_cell.sv
sv/eapf_parser.sv
sv/egress_packet_allowlist_filter_top.sv
tb/tb_egress_packet_allowlist_filter_top.sv
